// File: hw/rtl/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg: shared types and constants
// Item formats, widths of the exact integer datapath, region and edge codes.
// ----------------------------------------------------------------------------
package cpt_pkg;

  localparam int COORD_BITS       = 16;
  localparam int WEIGHT_FRAC_BITS = 16;

  // exact widths through the datapath
  localparam int DIFF_BITS   = COORD_BITS + 1;
  localparam int DOT_BITS    = 2 * DIFF_BITS + 2;
  localparam int PROD_BITS   = 2 * DOT_BITS;
  localparam int WIDE_BITS   = PROD_BITS + 3;
  localparam int LO_BITS     = DOT_BITS / 2;
  localparam int HI_BITS     = DOT_BITS - LO_BITS;
  localparam int WEIGHT_BITS = WEIGHT_FRAC_BITS + 1;

  localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};

  // nearest edge codes
  localparam logic [1:0] EDGE_AB   = 2'd0;
  localparam logic [1:0] EDGE_BC   = 2'd1;
  localparam logic [1:0] EDGE_CA   = 2'd2;
  localparam logic [1:0] EDGE_FACE = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    coord_t vert_a_x;
    coord_t vert_a_y;
    coord_t vert_a_z;
    coord_t vert_b_x;
    coord_t vert_b_y;
    coord_t vert_b_z;
    coord_t vert_c_x;
    coord_t vert_c_y;
    coord_t vert_c_z;
  } in_item_t;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] weight_u;
    logic [WEIGHT_BITS-1:0] weight_v;
    logic [WEIGHT_BITS-1:0] weight_w;
    logic [1:0]             edge_code;
    logic                   degenerate;
  } out_item_t;

  // the six dot products handed from front to back
  typedef struct packed {
    logic signed [DOT_BITS-1:0] d1;
    logic signed [DOT_BITS-1:0] d2;
    logic signed [DOT_BITS-1:0] d3;
    logic signed [DOT_BITS-1:0] d4;
    logic signed [DOT_BITS-1:0] d5;
    logic signed [DOT_BITS-1:0] d6;
  } dots_t;

  typedef enum logic [2:0] {
    REG_VERT_A  = 3'd0,
    REG_VERT_B  = 3'd1,
    REG_VERT_C  = 3'd2,
    REG_EDGE_AB = 3'd3,
    REG_EDGE_CA = 3'd4,
    REG_EDGE_BC = 3'd5,
    REG_FACE    = 3'd6
  } region_t;

  // sideband that rides along the divider
  typedef struct packed {
    region_t kind;
    logic    zero;
    logic    f0_zero;
    logic    f0_one;
    logic    f1_zero;
    logic    f1_one;
  } side_t;

endpackage

// File: hw/rtl/cpt_front.sv
// ----------------------------------------------------------------------------
// cpt_front: edge vectors and dot products
// Three registered stages: differences, lane products, dot sums.
// ----------------------------------------------------------------------------
module cpt_front
  import cpt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_item_t in_item,
  output logic     out_valid,
  output dots_t    out_dots,
  output logic [1:0] inflight
);

  coord_t p [3];
  coord_t a [3];
  coord_t b [3];
  coord_t c [3];

  logic signed [DIFF_BITS-1:0]   ab_r [3];
  logic signed [DIFF_BITS-1:0]   ac_r [3];
  logic signed [DIFF_BITS-1:0]   ap_r [3];
  logic signed [DIFF_BITS-1:0]   bp_r [3];
  logic signed [DIFF_BITS-1:0]   cp_r [3];
  logic signed [2*DIFF_BITS-1:0] prod_r [6][3];
  dots_t dots_r;
  logic  v1_r, v2_r, v3_r;

  function automatic logic signed [DIFF_BITS-1:0] sub_ext(input coord_t x, input coord_t y);
    return {x[COORD_BITS-1], x} - {y[COORD_BITS-1], y};
  endfunction

  function automatic logic signed [DOT_BITS-1:0] sum3(
    input logic signed [2*DIFF_BITS-1:0] x,
    input logic signed [2*DIFF_BITS-1:0] y,
    input logic signed [2*DIFF_BITS-1:0] z
  );
    return DOT_BITS'(x) + DOT_BITS'(y) + DOT_BITS'(z);
  endfunction

  assign p[0] = in_item.point_x;
  assign p[1] = in_item.point_y;
  assign p[2] = in_item.point_z;
  assign a[0] = in_item.vert_a_x;
  assign a[1] = in_item.vert_a_y;
  assign a[2] = in_item.vert_a_z;
  assign b[0] = in_item.vert_b_x;
  assign b[1] = in_item.vert_b_y;
  assign b[2] = in_item.vert_b_z;
  assign c[0] = in_item.vert_c_x;
  assign c[1] = in_item.vert_c_y;
  assign c[2] = in_item.vert_c_z;

  // stage 1: edge and point vectors
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ab_r[i] <= sub_ext(b[i], a[i]);
      ac_r[i] <= sub_ext(c[i], a[i]);
      ap_r[i] <= sub_ext(p[i], a[i]);
      bp_r[i] <= sub_ext(p[i], b[i]);
      cp_r[i] <= sub_ext(p[i], c[i]);
    end
  end

  // stage 2: per-axis products
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      prod_r[0][k] <= ab_r[k] * ap_r[k];
      prod_r[1][k] <= ac_r[k] * ap_r[k];
      prod_r[2][k] <= ab_r[k] * bp_r[k];
      prod_r[3][k] <= ac_r[k] * bp_r[k];
      prod_r[4][k] <= ab_r[k] * cp_r[k];
      prod_r[5][k] <= ac_r[k] * cp_r[k];
    end
  end

  // stage 3: dot sums
  always_ff @(posedge clk) begin
    dots_r.d1 <= sum3(prod_r[0][0], prod_r[0][1], prod_r[0][2]);
    dots_r.d2 <= sum3(prod_r[1][0], prod_r[1][1], prod_r[1][2]);
    dots_r.d3 <= sum3(prod_r[2][0], prod_r[2][1], prod_r[2][2]);
    dots_r.d4 <= sum3(prod_r[3][0], prod_r[3][1], prod_r[3][2]);
    dots_r.d5 <= sum3(prod_r[4][0], prod_r[4][1], prod_r[4][2]);
    dots_r.d6 <= sum3(prod_r[5][0], prod_r[5][1], prod_r[5][2]);
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_dots  = dots_r;
  assign inflight  = {1'b0, v1_r} + {1'b0, v2_r} + {1'b0, v3_r};

endmodule

// File: hw/rtl/cpt_queue.sv
// ----------------------------------------------------------------------------
// cpt_queue: dot product queue
// Small first-in first-out store between front and back, fall-through read.
// ----------------------------------------------------------------------------
module cpt_queue
  import cpt_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  dots_t push_data,
  input  logic  pop,
  output logic  not_empty,
  output dots_t head,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  dots_t          mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  // pointer wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign count     = count_r;

endmodule

// File: hw/rtl/cpt_div.sv
// ----------------------------------------------------------------------------
// cpt_div: pipelined restoring divider
// One quotient bit per stage; numerator below divisor on entry.
// ----------------------------------------------------------------------------
module cpt_div #(
  parameter int WIDTH = 8,
  parameter int STEPS = 8
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] rem_in,
  input  logic [WIDTH-1:0] den_in,
  output logic [STEPS-1:0] quo
);

  logic [WIDTH-1:0] rem_r [STEPS];
  logic [WIDTH-1:0] den_r [STEPS];
  logic [STEPS-1:0] quo_r [STEPS];
  logic [WIDTH-1:0] rem_src [STEPS];
  logic [WIDTH-1:0] den_src [STEPS];
  logic [STEPS-1:0] quo_src [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [WIDTH:0] trial;
    logic [WIDTH:0] diff;
    logic           ge;

    if (k == 0) begin : g_first
      assign rem_src[k] = rem_in;
      assign den_src[k] = den_in;
      assign quo_src[k] = '0;
    end else begin : g_next
      assign rem_src[k] = rem_r[k-1];
      assign den_src[k] = den_r[k-1];
      assign quo_src[k] = quo_r[k-1];
    end

    // shift, compare, subtract
    assign trial = {rem_src[k], 1'b0};
    assign diff  = trial - {1'b0, den_src[k]};
    assign ge    = (trial >= {1'b0, den_src[k]});

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      den_r[k] <= den_src[k];
      quo_r[k] <= {quo_src[k][STEPS-2:0], ge};
    end
  end

  assign quo = quo_r[STEPS-1];

endmodule

// File: hw/rtl/cpt_back.sv
// ----------------------------------------------------------------------------
// cpt_back: region classification and weights
// Split products, region tests, sign handling, two divider lanes, output.
// ----------------------------------------------------------------------------
module cpt_back
  import cpt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  dots_t     in_dots,
  output logic      out_strobe,
  output out_item_t out_result
);

  localparam int STEPS = WEIGHT_FRAC_BITS;

  logic signed [DOT_BITS-1:0]          opa [6];
  logic signed [DOT_BITS-1:0]          opb [6];
  logic signed [2*HI_BITS-1:0]         hh_r [6];
  logic signed [HI_BITS+LO_BITS:0]     hl_r [6];
  logic signed [HI_BITS+LO_BITS:0]     lh_r [6];
  logic [2*LO_BITS-1:0]                ll_r [6];
  logic signed [PROD_BITS-1:0]         prod_r [6];
  dots_t dots_b1_r, dots_b2_r;

  logic signed [WIDE_BITS-1:0] va_r, vb_r, vc_r, e43_r, e56_r, d13_r, d26_r;
  logic signed [WIDE_BITS-1:0] d1w_r, d2w_r, d3w_r, d6w_r;
  region_t                     kind4, kind4_r, kind5_r;
  logic signed [WIDE_BITS-1:0] n0_4, n1_4, den_4, den_face;
  logic signed [WIDE_BITS-1:0] n0_4r, n1_4r, den_4r;
  logic signed [WIDE_BITS-1:0] n0_5r, n1_5r, den_5r;
  logic                        zero_5r;
  logic [WIDE_BITS-1:0]        rem0_r, rem1_r, den6_r;
  side_t                       side6_r;
  side_t                       side_r [STEPS];
  logic                        dv_r [STEPS];
  logic                        v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic [STEPS-1:0]            quo0, quo1;
  logic [WEIGHT_BITS-1:0]      q0, q1, u_w, v_w, w_w;
  logic [WEIGHT_BITS+1:0]      face_u;
  logic [1:0]                  edge_w;
  logic                        degen_w;
  side_t                       side_o;
  out_item_t                   result_r;
  logic                        strobe_r;

  // operand pairs of the six wide products
  assign opa[0] = in_dots.d1;  assign opb[0] = in_dots.d4;
  assign opa[1] = in_dots.d3;  assign opb[1] = in_dots.d2;
  assign opa[2] = in_dots.d5;  assign opb[2] = in_dots.d2;
  assign opa[3] = in_dots.d1;  assign opb[3] = in_dots.d6;
  assign opa[4] = in_dots.d3;  assign opb[4] = in_dots.d6;
  assign opa[5] = in_dots.d5;  assign opb[5] = in_dots.d4;

  // b1: partial products of split operands
  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      hh_r[i] <= $signed(opa[i][DOT_BITS-1:LO_BITS]) * $signed(opb[i][DOT_BITS-1:LO_BITS]);
      hl_r[i] <= $signed(opa[i][DOT_BITS-1:LO_BITS]) * $signed({1'b0, opb[i][LO_BITS-1:0]});
      lh_r[i] <= $signed({1'b0, opa[i][LO_BITS-1:0]}) * $signed(opb[i][DOT_BITS-1:LO_BITS]);
      ll_r[i] <= opa[i][LO_BITS-1:0] * opb[i][LO_BITS-1:0];
    end
    dots_b1_r <= in_dots;
  end

  // b2: assemble the wide products
  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      prod_r[i] <= (PROD_BITS'(hh_r[i]) <<< (2 * LO_BITS))
                 + ((PROD_BITS'(hl_r[i]) + PROD_BITS'(lh_r[i])) <<< LO_BITS)
                 + $signed(PROD_BITS'(ll_r[i]));
    end
    dots_b2_r <= dots_b1_r;
  end

  // b3: region determinants and dot differences
  always_ff @(posedge clk) begin
    vc_r  <= WIDE_BITS'(prod_r[0]) - WIDE_BITS'(prod_r[1]);
    vb_r  <= WIDE_BITS'(prod_r[2]) - WIDE_BITS'(prod_r[3]);
    va_r  <= WIDE_BITS'(prod_r[4]) - WIDE_BITS'(prod_r[5]);
    e43_r <= WIDE_BITS'(dots_b2_r.d4) - WIDE_BITS'(dots_b2_r.d3);
    e56_r <= WIDE_BITS'(dots_b2_r.d5) - WIDE_BITS'(dots_b2_r.d6);
    d13_r <= WIDE_BITS'(dots_b2_r.d1) - WIDE_BITS'(dots_b2_r.d3);
    d26_r <= WIDE_BITS'(dots_b2_r.d2) - WIDE_BITS'(dots_b2_r.d6);
    d1w_r <= WIDE_BITS'(dots_b2_r.d1);
    d2w_r <= WIDE_BITS'(dots_b2_r.d2);
    d3w_r <= WIDE_BITS'(dots_b2_r.d3);
    d6w_r <= WIDE_BITS'(dots_b2_r.d6);
  end

  // b4: region tests in priority order, then quotient operands
  assign den_face = va_r + vb_r + vc_r;

  always_comb begin
    if (d1w_r <= 0 && d2w_r <= 0) begin
      kind4 = REG_VERT_A;
    end else if (d3w_r >= 0 && e43_r <= 0) begin
      kind4 = REG_VERT_B;
    end else if (vc_r <= 0 && d1w_r >= 0 && d3w_r <= 0) begin
      kind4 = REG_EDGE_AB;
    end else if (d6w_r >= 0 && e56_r <= 0) begin
      kind4 = REG_VERT_C;
    end else if (vb_r <= 0 && d2w_r >= 0 && d6w_r <= 0) begin
      kind4 = REG_EDGE_CA;
    end else if (va_r <= 0 && e43_r >= 0 && e56_r >= 0) begin
      kind4 = REG_EDGE_BC;
    end else begin
      kind4 = REG_FACE;
    end

    n0_4  = '0;
    n1_4  = '0;
    den_4 = WIDE_BITS'(1);
    case (kind4)
      REG_EDGE_AB: begin
        n0_4  = d1w_r;
        den_4 = d13_r;
      end
      REG_EDGE_CA: begin
        n0_4  = d2w_r;
        den_4 = d26_r;
      end
      REG_EDGE_BC: begin
        n0_4  = e43_r;
        den_4 = e43_r + e56_r;
      end
      REG_FACE: begin
        n0_4  = vb_r;
        n1_4  = vc_r;
        den_4 = den_face;
      end
      default: begin
        n0_4  = '0;
        n1_4  = '0;
        den_4 = WIDE_BITS'(1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    kind4_r <= kind4;
    n0_4r   <= n0_4;
    n1_4r   <= n1_4;
    den_4r  <= den_4;
  end

  // b5: make the divisor positive
  always_ff @(posedge clk) begin
    kind5_r <= kind4_r;
    zero_5r <= (den_4r == '0);
    if (den_4r[WIDE_BITS-1]) begin
      n0_5r  <= -n0_4r;
      n1_5r  <= -n1_4r;
      den_5r <= -den_4r;
    end else begin
      n0_5r  <= n0_4r;
      n1_5r  <= n1_4r;
      den_5r <= den_4r;
    end
  end

  // b6: saturate at zero or one, else hand to the dividers
  always_ff @(posedge clk) begin
    side6_r.kind    <= kind5_r;
    side6_r.zero    <= zero_5r;
    side6_r.f0_zero <= (n0_5r <= 0);
    side6_r.f0_one  <= (n0_5r >= den_5r);
    side6_r.f1_zero <= (n1_5r <= 0);
    side6_r.f1_one  <= (n1_5r >= den_5r);
    rem0_r <= (n0_5r <= 0 || n0_5r >= den_5r) ? '0 : n0_5r;
    rem1_r <= (n1_5r <= 0 || n1_5r >= den_5r) ? '0 : n1_5r;
    den6_r <= den_5r;
  end

  cpt_div #(
    .WIDTH (WIDE_BITS),
    .STEPS (STEPS)
  ) u_div0 (
    .clk    (clk),
    .rem_in (rem0_r),
    .den_in (den6_r),
    .quo    (quo0)
  );

  cpt_div #(
    .WIDTH (WIDE_BITS),
    .STEPS (STEPS)
  ) u_div1 (
    .clk    (clk),
    .rem_in (rem1_r),
    .den_in (den6_r),
    .quo    (quo1)
  );

  // sideband and valid alongside the dividers
  for (genvar k = 0; k < STEPS; k++) begin : g_side
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        side_r[k] <= side6_r;
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dv_r[k] <= 1'b0;
        end else begin
          dv_r[k] <= v6_r;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        side_r[k] <= side_r[k-1];
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dv_r[k] <= 1'b0;
        end else begin
          dv_r[k] <= dv_r[k-1];
        end
      end
    end
  end

  // stage valids ahead of the dividers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // weights per region
  assign side_o = side_r[STEPS-1];
  assign q0 = side_o.f0_zero ? '0 : (side_o.f0_one ? WEIGHT_ONE : {1'b0, quo0});
  assign q1 = side_o.f1_zero ? '0 : (side_o.f1_one ? WEIGHT_ONE : {1'b0, quo1});
  assign face_u = {2'b00, WEIGHT_ONE} - {2'b00, q0} - {2'b00, q1};

  always_comb begin
    u_w     = '0;
    v_w     = '0;
    w_w     = '0;
    edge_w  = EDGE_AB;
    degen_w = 1'b0;
    case (side_o.kind)
      REG_VERT_A: begin
        u_w    = WEIGHT_ONE;
        edge_w = EDGE_AB;
      end
      REG_VERT_B: begin
        v_w    = WEIGHT_ONE;
        edge_w = EDGE_BC;
      end
      REG_VERT_C: begin
        w_w    = WEIGHT_ONE;
        edge_w = EDGE_CA;
      end
      REG_EDGE_AB: begin
        v_w    = q0;
        u_w    = WEIGHT_ONE - q0;
        edge_w = EDGE_AB;
      end
      REG_EDGE_CA: begin
        w_w    = q0;
        u_w    = WEIGHT_ONE - q0;
        edge_w = EDGE_CA;
      end
      REG_EDGE_BC: begin
        w_w    = q0;
        v_w    = WEIGHT_ONE - q0;
        edge_w = EDGE_BC;
      end
      REG_FACE: begin
        v_w    = q0;
        w_w    = q1;
        u_w    = face_u[WEIGHT_BITS+1] ? '0 : face_u[WEIGHT_BITS-1:0];
        edge_w = EDGE_FACE;
      end
      default: begin
        u_w    = WEIGHT_ONE;
        edge_w = EDGE_AB;
      end
    endcase
    // degenerate triangle falls back to vertex a
    if (side_o.zero) begin
      u_w     = WEIGHT_ONE;
      v_w     = '0;
      w_w     = '0;
      edge_w  = EDGE_AB;
      degen_w = 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    result_r.weight_u   <= u_w;
    result_r.weight_v   <= v_w;
    result_r.weight_w   <= w_w;
    result_r.edge_code  <= edge_w;
    result_r.degenerate <= degen_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= dv_r[STEPS-1];
    end
  end

  assign out_strobe = strobe_r;
  assign out_result = result_r;

endmodule

// File: hw/rtl/closest_point_on_triangle_top.sv
// Throughput: one beat per cycle unless busy; the dividers take one quotient bit per stage, fully pipelined.
// busy rises only when queue fill plus front stages in flight reaches QUEUE_DEPTH.
// The receiver cannot stall: every result is shown for exactly one cycle.
// Reset (rst_n low, synchronous) empties the queue and clears all stage valids.
// ----------------------------------------------------------------------------
// closest_point_on_triangle_top: closest point on a triangle
// Front computes dot products, a queue decouples it from the back, which
// classifies the Voronoi region and forms barycentric weights.
// ----------------------------------------------------------------------------
module closest_point_on_triangle_top
  import cpt_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_result
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic          accept;
  logic          front_valid;
  dots_t         front_dots;
  logic [1:0]    inflight;
  logic          q_not_empty;
  dots_t         q_head;
  logic [CW-1:0] q_count;
  logic [CW:0]   occupancy;

  // room check covers everything already heading for the queue
  assign occupancy = (CW + 1)'(q_count) + (CW + 1)'(inflight);
  assign busy      = (occupancy >= (CW + 1)'(QUEUE_DEPTH));
  assign accept    = start && !busy;

  cpt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_item   (in_item),
    .out_valid (front_valid),
    .out_dots  (front_dots),
    .inflight  (inflight)
  );

  cpt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_valid),
    .push_data (front_dots),
    .pop       (q_not_empty),
    .not_empty (q_not_empty),
    .head      (q_head),
    .count     (q_count)
  );

  cpt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (q_not_empty),
    .in_dots    (q_head),
    .out_strobe (out_strobe),
    .out_result (out_result)
  );

endmodule

// File: hw/rtl/cpt_checker.sv
// ----------------------------------------------------------------------------
// cpt_checker: port level checks
// Watches the top level ports; attached by bind.
// ----------------------------------------------------------------------------
module cpt_checker
  import cpt_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      busy,
  input logic      out_strobe,
  input out_item_t out_result
);

  // weights never exceed one
  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_result.weight_u <= WEIGHT_ONE) && (out_result.weight_v <= WEIGHT_ONE)
                && (out_result.weight_w <= WEIGHT_ONE))
    else $error("weight above one");

  // degenerate beat is exactly vertex a
  a_degen_vertex: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_result.degenerate) |-> (out_result.weight_u == WEIGHT_ONE)
      && (out_result.weight_v == '0) && (out_result.weight_w == '0)
      && (out_result.edge_code == EDGE_AB))
    else $error("degenerate beat not vertex a");

  // outside the face the weights sum to one
  a_edge_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_result.edge_code != EDGE_FACE) |->
      ((WEIGHT_BITS + 2)'(out_result.weight_u) + (WEIGHT_BITS + 2)'(out_result.weight_v)
       + (WEIGHT_BITS + 2)'(out_result.weight_w)) == (WEIGHT_BITS + 2)'(WEIGHT_ONE))
    else $error("edge or vertex weights do not sum to one");

  // nothing comes out or blocks right after a reset cycle
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_strobe && !busy)
    else $error("activity straight after reset");

endmodule

bind closest_point_on_triangle_top cpt_checker u_cpt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_result (out_result)
);

// File: tb/tb_closest_point_on_triangle_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_closest_point_on_triangle_top: closest point on triangle testbench
// Drives query beats through the command handshake, predicts the weights and
// edge code with a wide integer model of the Voronoi classification, and
// checks every result strobe in order against the predicted queue.
// ----------------------------------------------------------------------------
module tb_closest_point_on_triangle_top;
  import cpt_pkg::*;

  // wide signed arithmetic for exact dot products and their products
  typedef logic signed [191:0] wide_t;

  // predicted results in arrival order
  class cpt_scoreboard;
    out_item_t pending[$];
    int        mismatches;

    static function automatic logic [WEIGHT_BITS-1:0] clampw(longint x);
      if (x < 0) return '0;
      if (x > (64'sd1 << WEIGHT_FRAC_BITS)) return WEIGHT_ONE;
      return x[WEIGHT_BITS-1:0];
    endfunction

    // truncated quotient clamped to 0..one
    static function automatic longint div_weight(wide_t n, wide_t d, ref bit zero);
      longint q;
      q = 0;
      if (d == 0) begin
        zero = 1;
        return 0;
      end
      if (d < 0) begin
        d = -d;
        n = -n;
      end
      if (n <= 0) return 0;
      if (n >= d) return 64'sd1 << WEIGHT_FRAC_BITS;
      for (int i = 0; i < WEIGHT_FRAC_BITS; i++) begin
        n = n <<< 1;
        q = q << 1;
        if (n >= d) begin
          n = n - d;
          q = q | 1;
        end
      end
      return q;
    endfunction

    static function automatic wide_t dot(wide_t x0, wide_t x1, wide_t x2,
                                         wide_t y0, wide_t y1, wide_t y2);
      return x0 * y0 + x1 * y1 + x2 * y2;
    endfunction

    static function automatic out_item_t closest_point(in_item_t it);
      wide_t p[3], a[3], b[3], c[3], ab[3], ac[3], ap[3], bp[3], cp[3];
      wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, n, den;
      longint u, v, w, one;
      logic [1:0] edge_sel;
      bit zero;
      out_item_t r;
      one = 64'sd1 << WEIGHT_FRAC_BITS;
      u = 0; v = 0; w = 0; zero = 0; edge_sel = EDGE_AB;
      p[0] = it.point_x;  p[1] = it.point_y;  p[2] = it.point_z;
      a[0] = it.vert_a_x; a[1] = it.vert_a_y; a[2] = it.vert_a_z;
      b[0] = it.vert_b_x; b[1] = it.vert_b_y; b[2] = it.vert_b_z;
      c[0] = it.vert_c_x; c[1] = it.vert_c_y; c[2] = it.vert_c_z;
      for (int i = 0; i < 3; i++) begin
        ab[i] = b[i] - a[i];
        ac[i] = c[i] - a[i];
        ap[i] = p[i] - a[i];
        bp[i] = p[i] - b[i];
        cp[i] = p[i] - c[i];
      end
      d1 = dot(ab[0], ab[1], ab[2], ap[0], ap[1], ap[2]);
      d2 = dot(ac[0], ac[1], ac[2], ap[0], ap[1], ap[2]);
      d3 = dot(ab[0], ab[1], ab[2], bp[0], bp[1], bp[2]);
      d4 = dot(ac[0], ac[1], ac[2], bp[0], bp[1], bp[2]);
      d5 = dot(ab[0], ab[1], ab[2], cp[0], cp[1], cp[2]);
      d6 = dot(ac[0], ac[1], ac[2], cp[0], cp[1], cp[2]);
      vc = d1 * d4 - d3 * d2;
      vb = d5 * d2 - d1 * d6;
      va = d3 * d6 - d5 * d4;
      // regions in priority order, first match wins
      if (d1 <= 0 && d2 <= 0) begin
        u = one; edge_sel = EDGE_AB;
      end else if (d3 >= 0 && d4 - d3 <= 0) begin
        v = one; edge_sel = EDGE_BC;
      end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
        v = div_weight(d1, d1 - d3, zero);
        u = one - v; edge_sel = EDGE_AB;
      end else if (d6 >= 0 && d5 - d6 <= 0) begin
        w = one; edge_sel = EDGE_CA;
      end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
        w = div_weight(d2, d2 - d6, zero);
        u = one - w; edge_sel = EDGE_CA;
      end else if (va <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0) begin
        n = d4 - d3;
        w = div_weight(n, n + (d5 - d6), zero);
        v = one - w; edge_sel = EDGE_BC;
      end else begin
        den = va + vb + vc;
        v = div_weight(vb, den, zero);
        w = div_weight(vc, den, zero);
        u = one - v - w; edge_sel = EDGE_FACE;
      end
      // zero divisor falls back to vertex a
      if (zero) begin
        u = one; v = 0; w = 0; edge_sel = EDGE_AB;
      end
      r.weight_u   = clampw(u);
      r.weight_v   = clampw(v);
      r.weight_w   = clampw(w);
      r.edge_code  = edge_sel;
      r.degenerate = zero;
      return r;
    endfunction

    function void note_query(in_item_t it);
      pending.insert(pending.size(), closest_point(it));
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected u=%0d v=%0d w=%0d edge=%0d deg=%0b, ",
                    "got u=%0d v=%0d w=%0d edge=%0d deg=%0b"},
                   exp_r.weight_u, exp_r.weight_v, exp_r.weight_w, exp_r.edge_code,
                   exp_r.degenerate, got.weight_u, got.weight_v, got.weight_w,
                   got.edge_code, got.degenerate);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_result;

  cpt_scoreboard sb;
  int idle_pct;
  int quiet_cycles;

  closest_point_on_triangle_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_strobe(out_strobe), .out_result(out_result)
  );

  always #6 clk = ~clk;

  // accepted beats on both sides, plus the watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_query(in_item);
      if (out_strobe) sb.check_result(out_result);
      if ((start && !busy) || out_strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
        $display("closest_point_on_triangle_top verification failed");
        $finish;
      end
    end
  end

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 2047) - 1024);
      default: return coord_t'($urandom_range(0, 31) - 16);
    endcase
  endfunction

  function automatic in_item_t rand_query();
    in_item_t it;
    int mode;
    coord_t base;
    mode = $urandom_range(0, 2);
    it = {rand_coord(mode), rand_coord(mode), rand_coord(mode),
          rand_coord(mode), rand_coord(mode), rand_coord(mode),
          rand_coord(mode), rand_coord(mode), rand_coord(mode),
          rand_coord(mode), rand_coord(mode), rand_coord(mode)};
    // sometimes collapse vertices for degenerate triangles
    case ($urandom_range(0, 9))
      0: begin
        it.vert_b_x = it.vert_a_x; it.vert_b_y = it.vert_a_y; it.vert_b_z = it.vert_a_z;
      end
      1: begin
        it.vert_c_x = it.vert_b_x; it.vert_c_y = it.vert_b_y; it.vert_c_z = it.vert_b_z;
      end
      2: begin
        base = rand_coord(2);
        it.vert_c_x = it.vert_b_x + base; it.vert_c_y = it.vert_b_y + base;
        it.vert_c_z = it.vert_b_z + base;
        it.vert_a_x = it.vert_b_x - base; it.vert_a_y = it.vert_b_y - base;
        it.vert_a_z = it.vert_b_z - base;
      end
      default: ;
    endcase
    return it;
  endfunction

  // one query beat, waiting on busy
  task automatic send_query(in_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic in_item_t tri_query(int px, int py, int pz);
    in_item_t it;
    it = '0;
    it.point_x = coord_t'(px); it.point_y = coord_t'(py); it.point_z = coord_t'(pz);
    it.vert_a_x = '0;       it.vert_a_y = '0;       it.vert_a_z = '0;
    it.vert_b_x = 16'h0400; it.vert_b_y = '0;       it.vert_b_z = '0;
    it.vert_c_x = '0;       it.vert_c_y = 16'h0400; it.vert_c_z = '0;
    return it;
  endfunction

  initial begin
    in_item_t it;
    clk = 0;
    rst_n = 0;
    start = 0;
    in_item = '0;
    idle_pct = 0;
    quiet_cycles = 0;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every region of a simple triangle, extremes, degenerate
    send_query(tri_query(-256, -256, 0));
    send_query(tri_query(2048, -100, 0));
    send_query(tri_query(512, -300, 77));
    send_query(tri_query(-50, 2048, 0));
    send_query(tri_query(-300, 512, -9));
    send_query(tri_query(800, 800, 40));
    send_query(tri_query(200, 300, 100));
    send_query(tri_query(0, 0, 0));
    send_query(tri_query(1024, 0, 0));
    send_query(tri_query(-32768, 32767, -32768));
    send_query(tri_query(32767, 32767, 32767));
    it = '0;
    send_query(it);
    it = '1;
    send_query(it);
    it = {16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000,
          16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
    send_query(it);
    it = {16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
          16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff};
    send_query(it);
    it = tri_query(100, 100, 0);
    it.vert_c_x = 16'h0800;
    send_query(it);

    // random phases
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 14 : (phase == 1) ? 69 : 0;
      for (int n = 0; n < 500; n++) begin
        send_query(rand_query());
        if (phase == 1 && n == 250) begin
          // hold off until the pipe drains
          start <= 1'b0;
          @(posedge clk);
          while (sb.pending.size() != 0) @(posedge clk);
        end
      end
    end
    start <= 1'b0;
    @(posedge clk);

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("closest_point_on_triangle_top verification clean");
    else
      $display("closest_point_on_triangle_top verification failed");
    $finish;
  end
endmodule
